### hw/rtl/mbec_pkg.sv
// Package for the escape-time counter: sequencer states, multiplier operand
// codes, register map and the control/status structs between sequencer and datapath.
// No dependencies.
`default_nettype none

package mbec_pkg;

	// Q4.28 format
	localparam int unsigned QFRAC = 28;

	// Register map, word index = paddr[4:2]
	localparam logic [2:0] REG_CORNER_R = 3'd0;
	localparam logic [2:0] REG_CORNER_I = 3'd1;
	localparam logic [2:0] REG_STEP_R   = 3'd2;
	localparam logic [2:0] REG_STEP_I   = 3'd3;
	localparam logic [2:0] REG_LIMIT    = 3'd4;

	// Reset values of the registers
	localparam logic [31:0] RST_CORNER_R = 32'hE800_0000;
	localparam logic [31:0] RST_CORNER_I = 32'h1800_0000;
	localparam logic [31:0] RST_STEP_R   = 32'h000C_0000;
	localparam logic [31:0] RST_STEP_I   = 32'hFFF4_0000;
	localparam logic [15:0] RST_LIMIT    = 16'd256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PT_R,
		ST_PT_I,
		ST_PT_C,
		ST_SQR_R,
		ST_SQR_I,
		ST_CROSS,
		ST_UPDATE,
		ST_DONE
	} state_t;

	// Operand pair for the shared multiplier
	typedef enum logic [2:0] {
		MUL_PX,
		MUL_PY,
		MUL_RR,
		MUL_II,
		MUL_RI
	} mul_op_t;

	// Source of the staged escape count
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_PREV,
		RES_LIMIT,
		RES_IDX
	} res_sel_t;

	typedef struct packed {
		logic     ready;
		mul_op_t  op;
		logic     ld_pix;
		logic     ld_cr;
		logic     ld_ci;
		logic     clr_z;
		logic     ld_rr;
		logic     ld_ii;
		logic     ld_ri;
		logic     ld_z;
		logic     ld_res;
		res_sel_t res_sel;
		logic     ld_out;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic pt_ovf;
		logic mag_esc;
		logic at_limit;
		logic z_ovf;
		logic slot_free;
	} stat_t;

endpackage

`default_nettype wire

### hw/rtl/mbec_mul.sv
// Shared signed 32x32 multiplier, full 64-bit product.
// Depends on nothing; the caller registers the product.
`default_nettype none

module mbec_mul (
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic signed [63:0]      p
);

	// Form the exact product
	assign p = 64'(a) * 64'(b);

endmodule

`default_nettype wire

### hw/rtl/mbec_seq.sv
// Sequencer for the escape-time counter: walks point setup and the
// four-step iteration loop. Depends on mbec_pkg.
`default_nettype none

module mbec_seq
	import mbec_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t stat,
	output ctrl_t      ctrl
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state; ready is high in idle, so a valid input is taken there
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (stat.in_valid) state_d = ST_PT_R;
			end
			ST_PT_R:  state_d = ST_PT_I;
			ST_PT_I:  state_d = ST_PT_C;
			ST_PT_C: begin
				state_d = stat.pt_ovf ? ST_DONE : ST_SQR_R;
			end
			ST_SQR_R: state_d = ST_SQR_I;
			ST_SQR_I: state_d = ST_CROSS;
			ST_CROSS: begin
				state_d = (stat.mag_esc || stat.at_limit) ? ST_DONE : ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = stat.z_ovf ? ST_DONE : ST_SQR_R;
			end
			ST_DONE: begin
				if (stat.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		ctrl         = '0;
		ctrl.op      = MUL_RR;
		ctrl.res_sel = RES_ZERO;
		case (state_q)
			ST_IDLE: begin
				ctrl.ready  = 1'b1;
				ctrl.ld_pix = stat.in_valid;
			end
			ST_PT_R: begin
				ctrl.op    = MUL_PX;
				ctrl.ld_ri = 1'b1;
			end
			ST_PT_I: begin
				ctrl.ld_cr = 1'b1;
				ctrl.op    = MUL_PY;
				ctrl.ld_ri = 1'b1;
			end
			ST_PT_C: begin
				ctrl.ld_ci   = 1'b1;
				ctrl.clr_z   = 1'b1;
				ctrl.ld_res  = stat.pt_ovf;
				ctrl.res_sel = RES_ZERO;
			end
			ST_SQR_R: begin
				ctrl.op    = MUL_RR;
				ctrl.ld_rr = 1'b1;
			end
			ST_SQR_I: begin
				ctrl.op    = MUL_II;
				ctrl.ld_ii = 1'b1;
			end
			ST_CROSS: begin
				ctrl.op = MUL_RI;
				if (stat.mag_esc) begin
					ctrl.ld_res  = 1'b1;
					ctrl.res_sel = RES_PREV;
				end else if (stat.at_limit) begin
					ctrl.ld_res  = 1'b1;
					ctrl.res_sel = RES_LIMIT;
				end else begin
					ctrl.ld_ri = 1'b1;
				end
			end
			ST_UPDATE: begin
				if (stat.z_ovf) begin
					ctrl.ld_res  = 1'b1;
					ctrl.res_sel = RES_IDX;
				end else begin
					ctrl.ld_z = 1'b1;
				end
			end
			ST_DONE: begin
				ctrl.ld_out = stat.slot_free;
			end
			default: ctrl = '0;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/mandelbrot_escape_count.sv
// Escape-time counter for z <- z*z - c in signed Q4.28, top level with
// datapath and register file. Depends on mbec_pkg, mbec_mul, mbec_seq.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata: pixel_x[11:0], pixel_y[23:12]
//   m_*       out  m_tvalid/m_tready  m_tdata: escape_count[15:0]
//   apb       in   psel/penable       5 registers at byte address 4*i
//
// The time from a pixel's input transaction to m_tvalid grows with u, the number
// of z updates (iteration_limit if nothing escapes), plus an update step for an
// iterate that leaves the format; a point off the format skips the loop. The shared
// 32x32 multiplier runs three times per iteration, then an update step.
// s_tready is high only while the sequencer idles, from the cycle m_tvalid rises;
// a result stalled by m_tready waits in a staging register. arst_n clears control.
`default_nettype none

module mandelbrot_escape_count
	import mbec_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // pixel_x[11:0], pixel_y[23:12]
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // escape_count[15:0]
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	ctrl_t ctrl;
	stat_t stat;

	logic signed [31:0] corner_r_q, corner_i_q, step_r_q, step_i_q;
	logic [15:0]        limit_q;

	logic [11:0]        px_q, py_q;
	logic signed [31:0] cr_q, ci_q, zr_q, zi_q;
	logic               cr_ovf_q;
	logic signed [63:0] rr_q, ii_q, ri_q;
	logic [15:0]        idx_q;
	logic [15:0]        res_q;
	logic               out_vld_q;
	logic [15:0]        out_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic signed [63:0] cr_sum, ci_sum, rdiff, nr_w, ni_w;
	logic [64:0]        mag;
	logic               cfg_wr, ci_ovf, nr_ovf, ni_ovf;

	// Configuration writes
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_r_q <= RST_CORNER_R;
			corner_i_q <= RST_CORNER_I;
			step_r_q   <= RST_STEP_R;
			step_i_q   <= RST_STEP_I;
			limit_q    <= RST_LIMIT;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_CORNER_R: corner_r_q <= pwdata;
				REG_CORNER_I: corner_i_q <= pwdata;
				REG_STEP_R:   step_r_q   <= pwdata;
				REG_STEP_I:   step_i_q   <= pwdata;
				REG_LIMIT:    limit_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[4:2])
			REG_CORNER_R: prdata = corner_r_q;
			REG_CORNER_I: prdata = corner_i_q;
			REG_STEP_R:   prdata = step_r_q;
			REG_STEP_I:   prdata = step_i_q;
			REG_LIMIT:    prdata = {16'd0, limit_q};
			default:      prdata = '0;
		endcase
	end

	// Select multiplier operands
	always_comb begin
		case (ctrl.op)
			MUL_PX: begin
				mul_a = $signed({20'd0, px_q});
				mul_b = step_r_q;
			end
			MUL_PY: begin
				mul_a = $signed({20'd0, py_q});
				mul_b = step_i_q;
			end
			MUL_RR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			MUL_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			MUL_RI: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
	end

	mbec_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	// Point setup: corner plus scaled pixel, range check
	assign cr_sum = 64'(corner_r_q) + ri_q;
	assign ci_sum = 64'(corner_i_q) + ri_q;
	assign ci_ovf = !((&ci_sum[63:31]) || !(|ci_sum[63:31]));

	// Escape test on the current z: zr^2 + zi^2 >= 2.0 in Q8.56
	assign mag = {1'b0, rr_q} + {1'b0, ii_q};

	// Next z: floor((rr - ii) / 2^28) - cr and floor(ri / 2^27) - ci
	assign rdiff  = rr_q - ii_q;
	assign nr_w   = (rdiff >>> QFRAC) - 64'(cr_q);
	assign ni_w   = (ri_q >>> (QFRAC - 1)) - 64'(ci_q);
	assign nr_ovf = !((&nr_w[63:31]) || !(|nr_w[63:31]));
	assign ni_ovf = !((&ni_w[63:31]) || !(|ni_w[63:31]));

	assign stat.in_valid  = s_tvalid;
	assign stat.pt_ovf    = cr_ovf_q | ci_ovf;
	assign stat.mag_esc   = |mag[64:57];
	assign stat.at_limit  = (idx_q == limit_q);
	assign stat.z_ovf     = nr_ovf | ni_ovf;
	assign stat.slot_free = !out_vld_q || m_tready;

	mbec_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign s_tready = ctrl.ready;

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.ld_pix) begin
			px_q <= s_tdata[11:0];
			py_q <= s_tdata[23:12];
		end
		if (ctrl.ld_cr) begin
			cr_q     <= cr_sum[31:0];
			cr_ovf_q <= !((&cr_sum[63:31]) || !(|cr_sum[63:31]));
		end
		if (ctrl.ld_ci) ci_q <= ci_sum[31:0];
		if (ctrl.ld_rr) rr_q <= mul_p;
		if (ctrl.ld_ii) ii_q <= mul_p;
		if (ctrl.ld_ri) ri_q <= mul_p;
		if (ctrl.clr_z) begin
			zr_q  <= '0;
			zi_q  <= '0;
			idx_q <= '0;
		end else if (ctrl.ld_z) begin
			zr_q  <= nr_w[31:0];
			zi_q  <= ni_w[31:0];
			idx_q <= idx_q + 16'd1;
		end
		if (ctrl.ld_res) begin
			case (ctrl.res_sel)
				RES_ZERO:  res_q <= '0;
				RES_PREV:  res_q <= idx_q - 16'd1;
				RES_LIMIT: res_q <= limit_q;
				RES_IDX:   res_q <= idx_q;
				default:   res_q <= '0;
			endcase
		end
		if (ctrl.ld_out) out_q <= res_q;
	end

	// Output register valid: set on load, drop when the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire

### hw/rtl/mbec_checker.sv
// Port-level checks for the escape-time counter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module mbec_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Drop ready after an input transaction
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after an input transaction");

	// Ready falls only because an item was taken
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("ready fell without an input transaction");

	// No result rises while point setup runs
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid)
			##1 !$rose(m_tvalid))
		else $error("result appeared too early");

endmodule

bind mandelbrot_escape_count mbec_checker u_mbec_checker (.*);

`default_nettype wire

### dv/mandelbrot_escape_count_checker.sv
// Scoreboard for the escape-time counter. It follows the register writes, predicts
// the escape count of every accepted pixel, and checks the results in order.
// Depends on mbec_pkg for the register map and the fixed-point format.
`timescale 1ns / 1ps

module mandelbrot_escape_count_checker
	import mbec_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,   // pixel_x[11:0], pixel_y[23:12]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,   // escape_count[15:0]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic [31:0] prdata,
	input  wire logic        pready,
	input  wire logic        end_of_test,
	output int               fail_count,
	output int               pending,
	output int               checked_count
);

	localparam int MAX_PRINTED = 40;
	// 2.0 in Q8.56, the scale of a full-width square
	localparam logic [63:0] ESCAPE_BOUND = 64'd1 << 57;
	localparam longint Q_LOW = -(longint'(1) <<< 31);
	localparam longint Q_HIGH = (longint'(1) <<< 31) - 1;

	typedef struct {
		logic [11:0] px;
		logic [11:0] py;
		logic [15:0] count;
	} escape_entry_t;

	logic signed [31:0] corner_r;
	logic signed [31:0] corner_i;
	logic signed [31:0] step_r;
	logic signed [31:0] step_i;
	logic [15:0]        iter_limit;
	escape_entry_t      expected_counts[$];
	bit                 leftovers_done;

	task automatic report_mismatch(input string msg);
		// keep the log short on a badly broken block, but count everything
		if (fail_count < MAX_PRINTED)
			$display("[%0t] escape check: %s", $time, msg);
		fail_count++;
	endtask

	function automatic bit fits_q(input longint v);
		return v >= Q_LOW && v <= Q_HIGH;
	endfunction

	// Iterate z <- z*z - c from z = 0 with floor rounding at full product width
	function automatic logic [15:0] escape_index(input logic [11:0] px, input logic [11:0] py);
		longint      cr;
		longint      ci;
		longint      zr;
		longint      zi;
		longint      nr;
		longint      ni;
		logic [63:0] mag;
		cr = longint'(corner_r) + longint'(px) * longint'(step_r);
		ci = longint'(corner_i) + longint'(py) * longint'(step_i);
		// a point outside Q4.28 escapes before the first iteration
		if (!fits_q(cr) || !fits_q(ci))
			return 16'd0;
		zr = 0;
		zi = 0;
		for (int unsigned i = 0; i < iter_limit; i++) begin
			nr = (zr * zr - zi * zi - (cr <<< QFRAC)) >>> QFRAC;
			ni = (zr * zi - (ci <<< (QFRAC - 1))) >>> (QFRAC - 1);
			// an iterate that leaves the format counts as escaped here
			if (!fits_q(nr) || !fits_q(ni))
				return 16'(i);
			zr = nr;
			zi = ni;
			mag = 64'(zr * zr) + 64'(zi * zi);
			if (mag >= ESCAPE_BOUND)
				return 16'(i);
		end
		return iter_limit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		escape_entry_t head;
		logic [31:0]   want;
		if (!arst_n) begin
			corner_r = -402653184;
			corner_i = 402653184;
			step_r = 786432;
			step_i = -786432;
			iter_limit = 16'd256;
			expected_counts.delete();
			leftovers_done = 1'b0;
		end else begin
			// track register writes, check register reads
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[4:2])
					REG_CORNER_R: corner_r = pwdata;
					REG_CORNER_I: corner_i = pwdata;
					REG_STEP_R:   step_r = pwdata;
					REG_STEP_I:   step_i = pwdata;
					REG_LIMIT:    iter_limit = pwdata[15:0];
					default:      ;   // no register behind this address
					endcase
				end else begin
					case (paddr[4:2])
					REG_CORNER_R: want = corner_r;
					REG_CORNER_I: want = corner_i;
					REG_STEP_R:   want = step_r;
					REG_STEP_I:   want = step_i;
					REG_LIMIT:    want = {16'd0, iter_limit};
					default:      want = prdata;
					endcase
					if (prdata !== want)
						report_mismatch($sformatf("register %0d read %h, expected %h",
							paddr[4:2], prdata, want));
				end
			end

			// compare each result transaction with the oldest prediction
			if (m_tvalid && m_tready) begin
				if (expected_counts.size() == 0) begin
					report_mismatch($sformatf("escape_count %0d with no pixel outstanding",
						m_tdata));
				end else begin
					head = expected_counts.pop_front();
					checked_count++;
					if (m_tdata !== head.count)
						report_mismatch($sformatf("pixel (%0d,%0d): escape_count %0d, expected %0d",
							head.px, head.py, m_tdata, head.count));
				end
			end

			// predict each pixel transaction with the current settings
			if (s_tvalid && s_tready) begin
				head.px = s_tdata[11:0];
				head.py = s_tdata[23:12];
				head.count = escape_index(head.px, head.py);
				expected_counts.push_back(head);
			end

			if (end_of_test && !leftovers_done) begin
				leftovers_done = 1'b1;
				if (expected_counts.size() != 0)
					report_mismatch($sformatf("%0d escape counts never arrived",
						expected_counts.size()));
			end
			pending = expected_counts.size();
		end
	end

endmodule

### dv/mandelbrot_escape_count_tb.sv
// Testbench top for the escape-time counter: clock, reset, pixel and register
// stimulus, random stalls on both streams, watchdog and verdict.
// Depends on mbec_pkg, the RTL and mandelbrot_escape_count_checker.
`timescale 1ns / 1ps

module mandelbrot_escape_count_tb
	import mbec_pkg::*;
();

	localparam int RANDOM_PHASES = 27;
	localparam int PHASE_PIXELS = 60;
	localparam int CALM_PHASES = 3;
	localparam int DRAIN_CYCLES = 64;
	// the watchdog must outlast the slowest pixel (limit 65535, never escapes)
	localparam int WATCHDOG_LIMIT = 1_100_000;
	localparam logic [2:0] REG_UNMAPPED_FIRST = 3'd5;
	localparam int UNMAPPED_REGS = 3;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_ONE = 32'h1000_0000;
	localparam logic [31:0] Q_MINUS_ONE = 32'hF000_0000;
	localparam logic [15:0] LIMIT_MAX = 16'hFFFF;
	// random window: corner within +-2.5, step within +-2^-9
	localparam int unsigned VIEW_HALF = 671088640;
	localparam int unsigned VIEW_SPAN = 1342177280;
	localparam int unsigned STEP_HALF = 1 << 19;
	localparam int unsigned STEP_SPAN = 1 << 20;

	typedef enum {
		VIEW_WINDOW,
		RAW_BITS,
		EXTREME_CORNERS
	} setting_kind_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // pixel_x[11:0], pixel_y[23:12]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // escape_count[15:0]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        end_of_test;
	logic        idle_on;
	int          fail_count;
	int          pending;
	int          checked_count;
	int          pixels_sent;
	int          settings_used;
	int          quiet_cycles;

	mandelbrot_escape_count dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	mandelbrot_escape_count_checker escape_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.end_of_test   (end_of_test),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Stall the result stream in bursts while idling is enabled
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Abort when no transaction of any kind completes for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
			$display("** mandelbrot_escape_count: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Setup phase, access phase until pready, then the bus is left idle
	task automatic apb_transfer(input logic write, input logic [2:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_setting(input logic [31:0] cr, input logic [31:0] ci,
			input logic [31:0] sr, input logic [31:0] si, input logic [15:0] lim);
		apb_transfer(1'b1, REG_CORNER_R, cr);
		apb_transfer(1'b1, REG_CORNER_I, ci);
		apb_transfer(1'b1, REG_STEP_R, sr);
		apb_transfer(1'b1, REG_STEP_I, si);
		apb_transfer(1'b1, REG_LIMIT, {16'd0, lim});
		settings_used++;
	endtask

	task automatic read_all_registers();
		apb_transfer(1'b0, REG_CORNER_R, 32'd0);
		apb_transfer(1'b0, REG_CORNER_I, 32'd0);
		apb_transfer(1'b0, REG_STEP_R, 32'd0);
		apb_transfer(1'b0, REG_STEP_I, 32'd0);
		apb_transfer(1'b0, REG_LIMIT, 32'd0);
	endtask

	// Present one pixel, possibly after an idle burst, and hold it until taken
	task automatic push_pixel(input logic [11:0] px, input logic [11:0] py);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	// Drop valid and wait until every predicted count has come back
	task automatic drain_counts();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	function automatic logic [31:0] boundary_q(input int unsigned k);
		case (k)
		0:       return Q_MIN;
		1:       return Q_MAX;
		2:       return 32'd0;
		3:       return 32'hFFFF_FFFF;
		4:       return 32'd1;
		default: return Q_ONE;
		endcase
	endfunction

	initial begin
		setting_kind_t kind;
		int unsigned   pick;
		logic [31:0]   cr;
		logic [31:0]   ci;
		logic [31:0]   sr;
		logic [31:0]   si;
		logic [15:0]   lim;
		logic [11:0]   px;
		logic [11:0]   py;

		arst_n = 1'b0;
		idle_on = 1'b1;
		end_of_test <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pixels_sent = 0;
		settings_used = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, then the reset window: corner, origin, and points off the format
		read_all_registers();
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd512, 12'd512);     // c = 0, runs to the limit
		push_pixel(12'd4095, 12'd4095);
		push_pixel(12'd4095, 12'd0);
		push_pixel(12'd0, 12'd4095);
		push_pixel(12'd300, 12'd700);
		drain_counts();

		// Zero limit and a limit of one
		apb_transfer(1'b1, REG_LIMIT, 32'd0);
		push_pixel(12'd512, 12'd512);
		push_pixel(12'd4095, 12'd4095);
		drain_counts();
		apb_transfer(1'b1, REG_LIMIT, 32'd1);
		push_pixel(12'd512, 12'd512);
		push_pixel(12'd0, 12'd0);
		drain_counts();

		// First iterate leaves the format in the real part, then the imaginary part
		program_setting(Q_MIN, 32'd0, 32'd0, 32'd0, 16'd8);
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd4095, 12'd4095);
		drain_counts();
		program_setting(32'd0, Q_MIN, 32'd0, 32'd0, 16'd8);
		push_pixel(12'd17, 12'd4000);
		drain_counts();

		// Extreme corners and steps: c at the edge of the format and beyond it
		program_setting(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'd8);
		push_pixel(12'd0, 12'd0);
		push_pixel(12'd1, 12'd0);
		push_pixel(12'd0, 12'd1);
		drain_counts();
		program_setting(Q_MIN, Q_MIN, Q_MAX, Q_MAX, 16'd8);
		push_pixel(12'd1, 12'd1);
		push_pixel(12'd4095, 12'd4095);
		drain_counts();

		// Writes to addresses past the register map must change nothing
		for (int k = 0; k < UNMAPPED_REGS; k++)
			apb_transfer(1'b1, REG_UNMAPPED_FIRST + 3'(k), $urandom());
		read_all_registers();
		push_pixel(12'd1, 12'd1);
		drain_counts();

		// Largest limit: c = 0 never escapes, c = -1 escapes at the second iteration
		program_setting(32'd0, 32'd0, 32'd0, 32'd0, LIMIT_MAX);
		push_pixel(12'd0, 12'd0);
		drain_counts();
		program_setting(Q_MINUS_ONE, 32'd0, 32'd0, 32'd0, LIMIT_MAX);
		push_pixel(12'd0, 12'd0);
		drain_counts();

		// Random settings, each followed by a batch of pixels
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				kind = VIEW_WINDOW;
			else if (pick < 17)
				kind = RAW_BITS;
			else
				kind = EXTREME_CORNERS;
			idle_on = (p < RANDOM_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);
			case (kind)
			VIEW_WINDOW: begin
				cr = $urandom_range(0, VIEW_SPAN) - VIEW_HALF;
				ci = $urandom_range(0, VIEW_SPAN) - VIEW_HALF;
				sr = $urandom_range(0, STEP_SPAN) - STEP_HALF;
				si = $urandom_range(0, STEP_SPAN) - STEP_HALF;
				pick = $urandom_range(0, 19);
				if (pick == 0)
					lim = 16'($urandom_range(0, 3));
				else if (pick == 1)
					lim = 16'($urandom_range(64, 128));
				else
					lim = 16'($urandom_range(4, 48));
			end
			RAW_BITS: begin
				cr = $urandom();
				ci = $urandom();
				sr = $urandom();
				si = $urandom();
				lim = 16'($urandom_range(0, 40));
			end
			default: begin
				cr = boundary_q($urandom_range(0, 5));
				ci = boundary_q($urandom_range(0, 5));
				sr = boundary_q($urandom_range(0, 5));
				si = boundary_q($urandom_range(0, 5));
				lim = 16'($urandom_range(0, 15));
			end
			endcase
			program_setting(cr, ci, sr, si, lim);
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				// windows mostly stay on the small pixel range where c is in view
				if (kind == VIEW_WINDOW && $urandom_range(0, 7) != 0) begin
					px = 12'($urandom_range(0, 1023));
					py = 12'($urandom_range(0, 1023));
				end else begin
					px = 12'($urandom_range(0, 4095));
					py = 12'($urandom_range(0, 4095));
				end
				push_pixel(px, py);
			end
			drain_counts();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		$display("run: %0d pixels over %0d register settings, %0d escape counts compared",
			pixels_sent, settings_used, checked_count);
		$display("run: limits 0 to 65535, points and iterates off the format, unmapped writes");
		if (fail_count == 0)
			$display("** mandelbrot_escape_count: PASSED **");
		else
			$display("** mandelbrot_escape_count: FAILED **");
		$finish;
	end

endmodule
